// ===== hdl/assert_macros.svh =====
// Assertion macros shared by the sample splat accumulator RTL.
// Each macro samples on the rising edge of clock and is disabled in reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold on every clock edge.
`define SSA_ASSERT_HOLD(lbl, prop) \
   lbl: assert property (@(posedge clock) disable iff (reset) (prop)) \
      else $error("sample splat accumulator: invariant violated");

// Consequent must hold in the same cycle as the antecedent.
`define SSA_ASSERT_IMPL(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("sample splat accumulator: same-cycle implication violated");

// Consequent must hold in the cycle after the antecedent.
`define SSA_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("sample splat accumulator: next-cycle implication violated");

`endif

// ===== hdl/ssa_pkg.sv =====
// Package for the sample splat accumulator: field widths, codes, command type
// and the coordinate and saturation helpers. Depends on nothing.
package ssa_pkg;

   localparam int COORD_W            = 24;
   localparam int COLOR_W            = 16;
   localparam int SUM_W              = 40;
   localparam int COUNT_W            = 24;
   localparam int INDEX_W            = 16;
   localparam int DIM_W              = 9;
   localparam int PIX_W              = 8;
   localparam int LIN_W              = 17;
   localparam int LIMIT_W            = 25;
   localparam int CSR_INDEX_W        = 1;
   localparam int CSR_DATA_W         = 9;
   localparam int DIM_MAX            = 256;
   localparam int HALF_PIXEL         = 128;
   localparam int MAX_PIXELS_DEFAULT = 65536;
   localparam int QUEUE_DEPTH_DEFAULT = 2;

   // Operation codes
   localparam logic OP_ACCUMULATE = 1'b0;
   localparam logic OP_READ       = 1'b1;

   // Register indexes
   localparam logic [CSR_INDEX_W-1:0] REG_IMAGE_WIDTH  = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] REG_IMAGE_HEIGHT = 1'b1;

   // Classified command passed from front end to back end
   typedef struct packed {
      logic               is_read;
      logic               in_range;
      logic [LIN_W-1:0]   addr;
      logic [COLOR_W-1:0] red;
      logic [COLOR_W-1:0] green;
      logic [COLOR_W-1:0] blue;
   } cmd_type;

   // Status from back end to front end
   typedef struct packed {
      logic clearing;
   } back_status_type;

   // Zero acts as one, anything above the maximum acts as the maximum.
   function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] d);
      logic [DIM_W-1:0] r;
      if (d == '0) begin
         r = DIM_W'(1);
      end else if (d > DIM_W'(DIM_MAX)) begin
         r = DIM_W'(DIM_MAX);
      end else begin
         r = d;
      end
      return r;
   endfunction

   // Shift by half a pixel, truncate, clamp to [0, dim_m1].
   function automatic logic [PIX_W-1:0] to_pixel(input logic [COORD_W-1:0] pos,
                                                input logic [PIX_W-1:0]   dim_m1);
      logic [COORD_W:0]   v;
      logic [COORD_W-8:0] idx;
      logic [PIX_W-1:0]   r;
      v   = {pos[COORD_W-1], pos} - (COORD_W+1)'(HALF_PIXEL);
      idx = v[COORD_W:8];
      if (v[COORD_W]) begin
         r = '0;
      end else if (idx > (COORD_W-7)'(dim_m1)) begin
         r = dim_m1;
      end else begin
         r = idx[PIX_W-1:0];
      end
      return r;
   endfunction

   // Add a color sample to a channel sum, sticking at all ones.
   function automatic logic [SUM_W-1:0] sat_add(input logic [SUM_W-1:0]   s,
                                               input logic [COLOR_W-1:0] c);
      logic [SUM_W:0] r;
      r = {1'b0, s} + (SUM_W+1)'(c);
      return r[SUM_W] ? {SUM_W{1'b1}} : r[SUM_W-1:0];
   endfunction

endpackage

// ===== hdl/ssa_if.sv =====
// Channel interfaces of the sample splat accumulator: request, response and
// register write. Depends on ssa_pkg for field widths.
interface ssa_req_if;
   logic                             valid;
   logic                             ready;
   logic                             operation;
   logic                             sample_valid;
   logic [ssa_pkg::COORD_W-1:0]      sample_x;
   logic [ssa_pkg::COORD_W-1:0]      sample_y;
   logic [ssa_pkg::COLOR_W-1:0]      red;
   logic [ssa_pkg::COLOR_W-1:0]      green;
   logic [ssa_pkg::COLOR_W-1:0]      blue;
   logic [ssa_pkg::INDEX_W-1:0]      read_index;

   modport source(output valid, operation, sample_valid, sample_x, sample_y,
                  red, green, blue, read_index, input ready);
   modport sink(input valid, operation, sample_valid, sample_x, sample_y,
                red, green, blue, read_index, output ready);
endinterface

interface ssa_rsp_if;
   logic                           valid;
   logic                           ready;
   logic [ssa_pkg::SUM_W-1:0]      sum_red;
   logic [ssa_pkg::SUM_W-1:0]      sum_green;
   logic [ssa_pkg::SUM_W-1:0]      sum_blue;
   logic [ssa_pkg::COUNT_W-1:0]    sample_count;

   modport source(output valid, sum_red, sum_green, sum_blue, sample_count,
                  input ready);
   modport sink(input valid, sum_red, sum_green, sum_blue, sample_count,
                output ready);
endinterface

interface ssa_csr_if;
   logic                              valid;
   logic                              ready;
   logic [ssa_pkg::CSR_INDEX_W-1:0]   index;
   logic [ssa_pkg::CSR_DATA_W-1:0]    data;

   modport source(output valid, index, data, input ready);
   modport sink(input valid, index, data, output ready);
endinterface

// ===== hdl/ssa_front.sv =====
// Front end: holds the image size registers, accepts requests, maps sample
// positions to linear pixel addresses and pushes commands. Uses ssa_pkg, ssa_if.
module ssa_front #(
   parameter int MAX_PIXELS = ssa_pkg::MAX_PIXELS_DEFAULT
) (
   input  logic                     clock,
   input  logic                     reset,
   ssa_req_if.sink                  req,
   ssa_csr_if.sink                  csr,
   input  ssa_pkg::back_status_type status,
   output logic                     push_valid,
   input  logic                     push_ready,
   output ssa_pkg::cmd_type         push_data
);

   localparam logic [ssa_pkg::LIMIT_W-1:0] PIX_LIMIT = ssa_pkg::LIMIT_W'(MAX_PIXELS);

   logic [ssa_pkg::DIM_W-1:0]   width_ff, width_in;
   logic [ssa_pkg::PIX_W-1:0]   width_m1_ff, width_m1_in;
   logic [ssa_pkg::PIX_W-1:0]   height_m1_ff, height_m1_in;
   logic [ssa_pkg::DIM_W-1:0]   csr_dim;

   logic                        s1_valid_ff, s1_valid_in;
   logic                        s1_read_ff;
   logic [ssa_pkg::PIX_W-1:0]   s1_ix_ff;
   logic [ssa_pkg::PIX_W-1:0]   s1_iy_ff;
   logic [ssa_pkg::INDEX_W-1:0] s1_index_ff;
   logic [ssa_pkg::COLOR_W-1:0] s1_red_ff, s1_green_ff, s1_blue_ff;

   logic                        accept;
   logic                        keep;
   logic                        s1_done;
   logic [ssa_pkg::LIN_W-1:0]   lin_addr;
   logic                        in_range;

   // Register writes are always taken; store the effective size
   assign csr.ready = 1'b1;
   assign csr_dim   = ssa_pkg::eff_dim(csr.data);

   always_comb begin
      width_in     = width_ff;
      width_m1_in  = width_m1_ff;
      height_m1_in = height_m1_ff;
      if (csr.valid) begin
         unique case (csr.index)
            ssa_pkg::REG_IMAGE_WIDTH: begin
               width_in    = csr_dim;
               width_m1_in = ssa_pkg::PIX_W'(csr_dim - ssa_pkg::DIM_W'(1));
            end
            ssa_pkg::REG_IMAGE_HEIGHT: begin
               height_m1_in = ssa_pkg::PIX_W'(csr_dim - ssa_pkg::DIM_W'(1));
            end
            default: begin
               width_in = width_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff     <= ssa_pkg::DIM_W'(ssa_pkg::DIM_MAX);
         width_m1_ff  <= ssa_pkg::PIX_W'(ssa_pkg::DIM_MAX - 1);
         height_m1_ff <= ssa_pkg::PIX_W'(ssa_pkg::DIM_MAX - 1);
      end else begin
         width_ff     <= width_in;
         width_m1_ff  <= width_m1_in;
         height_m1_ff <= height_m1_in;
      end
   end

   // Linear address and range check of the held transaction
   always_comb begin
      if (s1_read_ff) begin
         lin_addr = ssa_pkg::LIN_W'(s1_index_ff);
      end else begin
         lin_addr = ssa_pkg::LIN_W'(ssa_pkg::LIN_W'(s1_iy_ff) * ssa_pkg::LIN_W'(width_ff))
                    + ssa_pkg::LIN_W'(s1_ix_ff);
      end
      in_range = ssa_pkg::LIMIT_W'(lin_addr) < PIX_LIMIT;
   end

   // Out-of-range accumulates drop here; reads always go on
   assign push_valid = s1_valid_ff && (s1_read_ff || in_range);
   assign s1_done    = s1_valid_ff && (push_ready || !(s1_read_ff || in_range));

   assign push_data.is_read  = s1_read_ff;
   assign push_data.in_range = in_range;
   assign push_data.addr     = lin_addr;
   assign push_data.red      = s1_red_ff;
   assign push_data.green    = s1_green_ff;
   assign push_data.blue     = s1_blue_ff;

   // Accept while the store is ready and the holding stage can move
   assign req.ready = !status.clearing && (!s1_valid_ff || s1_done);
   assign accept    = req.valid && req.ready;
   assign keep      = (req.operation == ssa_pkg::OP_READ) || req.sample_valid;

   always_comb begin
      if (accept) begin
         s1_valid_in = keep;
      end else if (s1_done) begin
         s1_valid_in = 1'b0;
      end else begin
         s1_valid_in = s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   // Capture payload and pixel coordinates on accept
   always_ff @(posedge clock) begin
      if (accept) begin
         s1_read_ff  <= (req.operation == ssa_pkg::OP_READ);
         s1_ix_ff    <= ssa_pkg::to_pixel(req.sample_x, width_m1_ff);
         s1_iy_ff    <= ssa_pkg::to_pixel(req.sample_y, height_m1_ff);
         s1_index_ff <= req.read_index;
         s1_red_ff   <= req.red;
         s1_green_ff <= req.green;
         s1_blue_ff  <= req.blue;
      end
   end

endmodule

// ===== hdl/ssa_queue.sv =====
// Command queue between front and back end of the sample splat accumulator.
// Uses ssa_pkg for the command type.
module ssa_queue #(
   parameter int DEPTH = ssa_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push_valid,
   output logic             push_ready,
   input  ssa_pkg::cmd_type push_data,
   output logic             pop_valid,
   input  logic             pop,
   output ssa_pkg::cmd_type pop_data
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

   ssa_pkg::cmd_type entries_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push;
   logic             do_pop;

   assign push_ready = (count_ff != CNT_W'(DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_data   = entries_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop && pop_valid;

   // Advance pointers with wrap, track fill level
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ===== hdl/ssa_back.sv =====
// Back end: owns the pixel store, clears it after reset, runs read-modify-write
// of accumulates and drives the response register. Uses ssa_pkg, ssa_if, macros.
`include "assert_macros.svh"

module ssa_back #(
   parameter int MAX_PIXELS = ssa_pkg::MAX_PIXELS_DEFAULT
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      cmd_valid,
   output logic                      cmd_pop,
   input  ssa_pkg::cmd_type          cmd_data,
   output ssa_pkg::back_status_type  status,
   ssa_rsp_if.source                 rsp
);

   localparam int ADDR_W = (MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1;
   localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(MAX_PIXELS - 1);

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_EXEC = 1'b1;

   typedef struct packed {
      logic [ssa_pkg::SUM_W-1:0]   red;
      logic [ssa_pkg::SUM_W-1:0]   green;
      logic [ssa_pkg::SUM_W-1:0]   blue;
      logic [ssa_pkg::COUNT_W-1:0] count;
   } entry_type;

   entry_type        store_ff [MAX_PIXELS];
   entry_type        rd_data_ff;
   entry_type        wr_data;
   entry_type        upd_data;
   logic [ADDR_W-1:0] wr_addr;
   logic              wr_en;

   logic              state_ff, state_in;
   logic              clearing_ff, clearing_in;
   logic [ADDR_W-1:0] clear_cnt_ff, clear_cnt_in;
   ssa_pkg::cmd_type  cmd_ff;
   logic              rsp_valid_ff, rsp_valid_in;
   entry_type         rsp_data_ff;
   logic              rsp_load;

   // Take a command when idle; a read needs a free response slot
   assign cmd_pop = (state_ff == ST_IDLE) && !clearing_ff && cmd_valid &&
                    (!cmd_data.is_read || !rsp_valid_ff);

   assign status.clearing = clearing_ff;

   // Next state, clearing sweep
   always_comb begin
      state_in     = state_ff;
      clearing_in  = clearing_ff;
      clear_cnt_in = clear_cnt_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (cmd_pop) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      if (clearing_ff) begin
         clear_cnt_in = clear_cnt_ff + ADDR_W'(1);
         if (clear_cnt_ff == LAST_ADDR) begin
            clearing_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         clearing_ff  <= 1'b1;
         clear_cnt_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clearing_ff  <= clearing_in;
         clear_cnt_ff <= clear_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Hold the command under execution
   always_ff @(posedge clock) begin
      if (cmd_pop) begin
         cmd_ff <= cmd_data;
      end
   end

   // Saturating update of the fetched entry
   always_comb begin
      upd_data.red   = ssa_pkg::sat_add(rd_data_ff.red, cmd_ff.red);
      upd_data.green = ssa_pkg::sat_add(rd_data_ff.green, cmd_ff.green);
      upd_data.blue  = ssa_pkg::sat_add(rd_data_ff.blue, cmd_ff.blue);
      upd_data.count = (rd_data_ff.count == {ssa_pkg::COUNT_W{1'b1}}) ?
                       rd_data_ff.count :
                       rd_data_ff.count + ssa_pkg::COUNT_W'(1);
   end

   // Write port: clearing sweep or write-back of an accumulate
   always_comb begin
      if (clearing_ff) begin
         wr_en   = 1'b1;
         wr_addr = clear_cnt_ff;
         wr_data = '0;
      end else begin
         wr_en   = (state_ff == ST_EXEC) && !cmd_ff.is_read && cmd_ff.in_range;
         wr_addr = ADDR_W'(cmd_ff.addr);
         wr_data = upd_data;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read at pop time
   always_ff @(posedge clock) begin
      if (cmd_pop) begin
         rd_data_ff <= store_ff[ADDR_W'(cmd_data.addr)];
      end
   end

   // Response register; out-of-range reads return zero
   assign rsp_load = (state_ff == ST_EXEC) && cmd_ff.is_read;

   always_comb begin
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_data_ff <= cmd_ff.in_range ? rd_data_ff : '0;
      end
   end

   assign rsp.valid        = rsp_valid_ff;
   assign rsp.sum_red      = rsp_data_ff.red;
   assign rsp.sum_green    = rsp_data_ff.green;
   assign rsp.sum_blue     = rsp_data_ff.blue;
   assign rsp.sample_count = rsp_data_ff.count;

   `SSA_ASSERT_IMPL(a_no_pop_while_clearing, clearing_ff, !cmd_pop)
   `SSA_ASSERT_NEXT(a_exec_one_cycle, state_ff == ST_EXEC, state_ff == ST_IDLE)
   `SSA_ASSERT_IMPL(a_rsp_slot_free, rsp_load, !rsp_valid_ff)
   `SSA_ASSERT_IMPL(a_rsp_from_read, $rose(rsp_valid_ff), $past(rsp_load))

endmodule

// ===== hdl/sample_splat_accumulator_top.sv =====
// Sample splat accumulator: a read passes the front-end holding stage, the
// command queue, the back-end fetch and the response register; accumulates
// give no response. Each transaction is a read-modify-write on the pixel
// store, done before the next is taken; a read also waits for an empty
// response register. The front end takes one per cycle into a short queue
// while it has room. Synchronous reset, then a clearing pass over all
// MAX_PIXELS store entries during which req_port.ready stays low.
module sample_splat_accumulator_top #(
   parameter int MAX_PIXELS  = ssa_pkg::MAX_PIXELS_DEFAULT,
   parameter int QUEUE_DEPTH = ssa_pkg::QUEUE_DEPTH_DEFAULT
) (
   input logic       clock,
   input logic       reset,
   ssa_req_if.sink   req_port,
   ssa_rsp_if.source rsp_port,
   ssa_csr_if.sink   csr_port
);

   ssa_pkg::back_status_type back_status;
   logic                     push_valid;
   logic                     push_ready;
   ssa_pkg::cmd_type         push_data;
   logic                     cmd_valid;
   logic                     cmd_pop;
   ssa_pkg::cmd_type         cmd_data;

   // Classify requests
   ssa_front #(
      .MAX_PIXELS(MAX_PIXELS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req        (req_port),
      .csr        (csr_port),
      .status     (back_status),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data)
   );

   // Decouple front and back
   ssa_queue #(
      .DEPTH(QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data),
      .pop_valid  (cmd_valid),
      .pop        (cmd_pop),
      .pop_data   (cmd_data)
   );

   // Execute against the pixel store
   ssa_back #(
      .MAX_PIXELS(MAX_PIXELS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (cmd_valid),
      .cmd_pop   (cmd_pop),
      .cmd_data  (cmd_data),
      .status    (back_status),
      .rsp       (rsp_port)
   );

endmodule

// ===== sim/tb.sv =====
// Self-checking testbench for sample_splat_accumulator_top: directed table, then
// random phases under several image sizes, checked against an in-bench pixel store.
// Depends on ssa_pkg, the ssa_*_if interfaces and the accumulator RTL.
module tb;
   import ssa_pkg::*;

   localparam int STORE_DEPTH     = MAX_PIXELS_DEFAULT;
   localparam int SETTLE_CYCLES   = 16;
   localparam int WATCHDOG_LIMIT  = 200000;
   localparam int ITEMS_PER_PHASE = 140;
   localparam int PHASE_COUNT     = 9;
   localparam int RECENT_DEPTH    = 64;
   localparam int DIRECTED_COUNT  = 21;

   typedef struct packed {
      bit                   operation;
      bit                   sample_valid;
      bit [COORD_W-1:0]     sample_x;
      bit [COORD_W-1:0]     sample_y;
      bit [COLOR_W-1:0]     red;
      bit [COLOR_W-1:0]     green;
      bit [COLOR_W-1:0]     blue;
      bit [INDEX_W-1:0]     read_index;
   } sample_req_type;

   typedef struct packed {
      bit [SUM_W-1:0]       sum_red;
      bit [SUM_W-1:0]       sum_green;
      bit [SUM_W-1:0]       sum_blue;
      bit [COUNT_W-1:0]     sample_count;
   } pixel_sums_type;

   typedef struct packed {
      bit                   operation;
      bit                   sample_valid;
      bit [COORD_W-1:0]     sample_x;
      bit [COORD_W-1:0]     sample_y;
      bit [COLOR_W-1:0]     red;
      bit [COLOR_W-1:0]     green;
      bit [COLOR_W-1:0]     blue;
      bit [INDEX_W-1:0]     read_index;
      bit                   typed;
      bit [SUM_W-1:0]       want_red;
      bit [SUM_W-1:0]       want_green;
      bit [SUM_W-1:0]       want_blue;
      bit [COUNT_W-1:0]     want_count;
   } table_row_type;

   // Directed rows at the reset image size of 256 by 256
   localparam table_row_type DIRECTED_ROWS [DIRECTED_COUNT] = '{
      '{OP_READ, 1'b0, 24'h000000, 24'h000000, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
        1'b1, 40'h0, 40'h0, 40'h0, 24'h0},
      '{OP_READ, 1'b0, 24'h000000, 24'h000000, 16'h0000, 16'h0000, 16'h0000, 16'hFFFF,
        1'b1, 40'h0, 40'h0, 40'h0, 24'h0},
      '{OP_ACCUMULATE, 1'b1, 24'h000080, 24'h000080, 16'hFFFF, 16'hFFFF, 16'hFFFF,
        16'hAAAA, 1'b0, 40'h0, 40'h0, 40'h0, 24'h0},
      '{OP_ACCUMULATE, 1'b1, 24'h000000, 24'h000000, 16'h0001, 16'h0002, 16'h0003,
        16'h5555, 1'b0, 40'h0, 40'h0, 40'h0, 24'h0},
      '{OP_ACCUMULATE, 1'b1, 24'h800000, 24'h800000, 16'h0000, 16'h0000, 16'h0000,
        16'hFFFF, 1'b0, 40'h0, 40'h0, 40'h0, 24'h0},
      '{OP_ACCUMULATE, 1'b0, 24'h000080, 24'h000080, 16'hFFFF, 16'hFFFF, 16'hFFFF,
        16'h0000, 1'b0, 40'h0, 40'h0, 40'h0, 24'h0},
      '{OP_READ, 1'b0, 24'hFFFFFF, 24'hFFFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h0000,
        1'b1, 40'h10000, 40'h10001, 40'h10002, 24'h3},
      '{OP_ACCUMULATE, 1'b1, 24'h7FFFFF, 24'h7FFFFF, 16'h00AA, 16'h5500, 16'h1234,
        16'h0000, 1'b0, 40'h0, 40'h0, 40'h0, 24'h0},
      '{OP_READ, 1'b0, 24'h000000, 24'h000000, 16'h0000, 16'h0000, 16'h0000, 16'hFFFF,
        1'b1, 40'hAA, 40'h5500, 40'h1234, 24'h1},
      '{OP_ACCUMULATE, 1'b1, 24'h00017F, 24'h000180, 16'h8000, 16'h0001, 16'h7FFF,
        16'h0000, 1'b0, 40'h0, 40'h0, 40'h0, 24'h0},
      '{OP_READ, 1'b0, 24'h000000, 24'h000000, 16'h0000, 16'h0000, 16'h0000, 16'h0100,
        1'b1, 40'h8000, 40'h1, 40'h7FFF, 24'h1},
      '{OP_READ, 1'b0, 24'h000000, 24'h000000, 16'h0000, 16'h0000, 16'h0000, 16'h00FF,
        1'b1, 40'h0, 40'h0, 40'h0, 24'h0},
      '{OP_ACCUMULATE, 1'b1, 24'h00FF80, 24'h000080, 16'h0F0F, 16'hF0F0, 16'h3C3C,
        16'h0000, 1'b0, 40'h0, 40'h0, 40'h0, 24'h0},
      '{OP_READ, 1'b0, 24'h000000, 24'h000000, 16'h0000, 16'h0000, 16'h0000, 16'h00FF,
        1'b1, 40'h0F0F, 40'hF0F0, 40'h3C3C, 24'h1},
      '{OP_ACCUMULATE, 1'b1, 24'h000100, 24'h000200, 16'h0001, 16'h0001, 16'h0001,
        16'h0000, 1'b0, 40'h0, 40'h0, 40'h0, 24'h0},
      '{OP_READ, 1'b0, 24'h000000, 24'h000000, 16'h0000, 16'h0000, 16'h0000, 16'h0100,
        1'b1, 40'h8001, 40'h2, 40'h8000, 24'h2},
      '{OP_ACCUMULATE, 1'b1, 24'h400000, 24'hFFFFFF, 16'h1111, 16'h2222, 16'h3333,
        16'h0000, 1'b0, 40'h0, 40'h0, 40'h0, 24'h0},
      '{OP_READ, 1'b1, 24'h000000, 24'h000000, 16'h0000, 16'h0000, 16'h0000, 16'h00FF,
        1'b0, 40'h0, 40'h0, 40'h0, 24'h0},
      '{OP_ACCUMULATE, 1'b1, 24'h7FFF80, 24'h000180, 16'hFFFF, 16'h0000, 16'hFFFF,
        16'h0000, 1'b0, 40'h0, 40'h0, 40'h0, 24'h0},
      '{OP_READ, 1'b0, 24'h000000, 24'h000000, 16'h0000, 16'h0000, 16'h0000, 16'h01FF,
        1'b0, 40'h0, 40'h0, 40'h0, 24'h0},
      '{OP_READ, 1'b1, 24'h000000, 24'h000000, 16'h0000, 16'h0000, 16'h0000, 16'h8000,
        1'b1, 40'h0, 40'h0, 40'h0, 24'h0}
   };

   logic clock;
   logic reset;

   ssa_req_if req_if();
   ssa_rsp_if rsp_if();
   ssa_csr_if csr_if();

   sample_splat_accumulator_top DUT (
      .clock    (clock),
      .reset    (reset),
      .req_port (req_if),
      .rsp_port (rsp_if),
      .csr_port (csr_if)
   );

   // Mirror of the pixel store and the image size registers
   bit [SUM_W-1:0]   mirror_red   [STORE_DEPTH];
   bit [SUM_W-1:0]   mirror_green [STORE_DEPTH];
   bit [SUM_W-1:0]   mirror_blue  [STORE_DEPTH];
   bit [COUNT_W-1:0] mirror_count [STORE_DEPTH];
   bit [DIM_W-1:0]   cfg_width  = DIM_W'(DIM_MAX);
   bit [DIM_W-1:0]   cfg_height = DIM_W'(DIM_MAX);

   pixel_sums_type pending_pixel_reads [$];
   int             recent_pixels [$];
   int             mismatch_count = 0;
   int             quiet_cycles   = 0;

   initial clock = 1'b0;
   always #5 clock = ~clock;

   // Zero acts as one, anything past the store row size acts as 256.
   function automatic int dim_effective(input bit [DIM_W-1:0] d);
      if (d == 0) return 1;
      if (d > DIM_MAX) return DIM_MAX;
      return int'(d);
   endfunction

   // Remove half a pixel, truncate toward zero and clamp into [0, dim-1].
   function automatic int pixel_coord(input bit [COORD_W-1:0] pos, input int dim);
      int v;
      v = int'($signed(pos)) - HALF_PIXEL;
      if (v < 0) return 0;
      v = v / 256;
      if (v > dim - 1) return dim - 1;
      return v;
   endfunction

   function automatic bit [SUM_W-1:0] sum_clip(input bit [SUM_W-1:0] s,
                                                input bit [COLOR_W-1:0] c);
      bit [SUM_W:0] t;
      t = {1'b0, s} + (SUM_W+1)'(c);
      return t[SUM_W] ? {SUM_W{1'b1}} : t[SUM_W-1:0];
   endfunction

   // Update the mirror for one accepted transaction; queue the read result.
   task automatic record_request(input sample_req_type item, input bit typed,
                                 input pixel_sums_type typed_sums);
      pixel_sums_type   sums;
      int               w;
      int               h;
      int               addr;
      bit [INDEX_W-1:0] slot;
      if (item.operation == OP_READ) begin
         if (typed) begin
            sums = typed_sums;
         end else if (int'(item.read_index) < STORE_DEPTH) begin
            sums.sum_red      = mirror_red[item.read_index];
            sums.sum_green    = mirror_green[item.read_index];
            sums.sum_blue     = mirror_blue[item.read_index];
            sums.sample_count = mirror_count[item.read_index];
         end else begin
            sums = '0;
         end
         pending_pixel_reads.push_back(sums);
      end else if (item.sample_valid) begin
         w    = dim_effective(cfg_width);
         h    = dim_effective(cfg_height);
         addr = pixel_coord(item.sample_y, h) * w + pixel_coord(item.sample_x, w);
         if (addr < STORE_DEPTH) begin
            slot               = INDEX_W'(addr);
            mirror_red[slot]   = sum_clip(mirror_red[slot], item.red);
            mirror_green[slot] = sum_clip(mirror_green[slot], item.green);
            mirror_blue[slot]  = sum_clip(mirror_blue[slot], item.blue);
            if (mirror_count[slot] != {COUNT_W{1'b1}}) begin
               mirror_count[slot] = mirror_count[slot] + COUNT_W'(1);
            end
            recent_pixels.push_back(addr);
            if (recent_pixels.size() > RECENT_DEPTH) void'(recent_pixels.pop_front());
         end
      end
   endtask

   // Drive one transaction at the falling edge and hold it until accepted.
   task automatic send_request(input sample_req_type item, input bit typed,
                               input pixel_sums_type typed_sums);
      @(negedge clock);
      req_if.valid        <= 1'b1;
      req_if.operation    <= item.operation;
      req_if.sample_valid <= item.sample_valid;
      req_if.sample_x     <= item.sample_x;
      req_if.sample_y     <= item.sample_y;
      req_if.red          <= item.red;
      req_if.green        <= item.green;
      req_if.blue         <= item.blue;
      req_if.read_index   <= item.read_index;
      do @(posedge clock); while (req_if.ready !== 1'b1);
      record_request(item, typed, typed_sums);
   endtask

   task automatic idle_request(input int cycles);
      if (cycles > 0) begin
         @(negedge clock);
         req_if.valid <= 1'b0;
         repeat (cycles - 1) @(negedge clock);
      end
   endtask

   // Hold the sender until every read result is back and the pipeline is quiet.
   task automatic drain_pending();
      @(negedge clock);
      req_if.valid <= 1'b0;
      while (pending_pixel_reads.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_register(input logic [CSR_INDEX_W-1:0] index,
                                 input bit [DIM_W-1:0] value);
      @(negedge clock);
      csr_if.valid <= 1'b1;
      csr_if.index <= index;
      csr_if.data  <= value;
      do @(posedge clock); while (csr_if.ready !== 1'b1);
      if (index == REG_IMAGE_WIDTH) cfg_width = value;
      else cfg_height = value;
      @(negedge clock);
      csr_if.valid <= 1'b0;
   endtask

   // Mostly back to back, some short gaps, a few long ones.
   function automatic int draw_pause();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 70) return 0;
      if (roll < 94) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // Mostly near the image so clamps and interior pixels both occur.
   function automatic bit [COORD_W-1:0] draw_position(input int dim);
      int p;
      if ($urandom_range(0, 99) < 85) begin
         p = int'($urandom_range(0, (dim + 2) * 256)) - 256;
         return COORD_W'(p);
      end
      return COORD_W'($urandom);
   endfunction

   function automatic bit [COLOR_W-1:0] draw_color();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 10) return {COLOR_W{1'b1}};
      if (roll < 15) return '0;
      return COLOR_W'($urandom);
   endfunction

   // Mostly revisit pixels that were just written.
   function automatic bit [INDEX_W-1:0] draw_read_index();
      int roll;
      roll = $urandom_range(0, 99);
      if (recent_pixels.size() != 0 && roll < 75) begin
         return INDEX_W'(recent_pixels[$urandom_range(0, recent_pixels.size() - 1)]);
      end
      if (roll < 80) return '0;
      if (roll < 85) return {INDEX_W{1'b1}};
      return INDEX_W'($urandom);
   endfunction

   task automatic run_random_phase(input int item_goal, input bit calm);
      sample_req_type item;
      pixel_sums_type none;
      int             served;
      int             roll;
      int             w;
      int             h;
      none   = '0;
      served = 0;
      w      = dim_effective(cfg_width);
      h      = dim_effective(cfg_height);
      while (served < item_goal) begin
         // Fill every field at random, then shape by kind
         item.operation    = OP_ACCUMULATE;
         item.sample_valid = 1'($urandom);
         item.sample_x     = COORD_W'($urandom);
         item.sample_y     = COORD_W'($urandom);
         item.red          = COLOR_W'($urandom);
         item.green        = COLOR_W'($urandom);
         item.blue         = COLOR_W'($urandom);
         item.read_index   = INDEX_W'($urandom);
         roll = $urandom_range(0, 99);
         if (roll < 65) begin
            item.sample_valid = 1'b1;
            item.sample_x     = draw_position(w);
            item.sample_y     = draw_position(h);
            item.red          = draw_color();
            item.green        = draw_color();
            item.blue         = draw_color();
         end else if (roll < 90) begin
            item.operation  = OP_READ;
            item.read_index = draw_read_index();
         end else begin
            item.sample_valid = 1'b0;
         end
         send_request(item, 1'b0, none);
         served++;
         idle_request(calm ? 0 : draw_pause());
      end
   endtask

   task automatic report_mismatch(input string what, input logic [SUM_W-1:0] got,
                                  input logic [SUM_W-1:0] want);
      $display("MISMATCH %s: got %h, want %h at %0t", what, got, want, $time);
      mismatch_count++;
   endtask

   // Compare each accepted response with the oldest pending read.
   always @(posedge clock) begin
      pixel_sums_type want;
      if (reset === 1'b0 && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
         if (pending_pixel_reads.size() == 0) begin
            report_mismatch("unexpected response, count", SUM_W'(rsp_if.sample_count),
                            '0);
         end else begin
            want = pending_pixel_reads.pop_front();
            if (rsp_if.sum_red !== want.sum_red)
               report_mismatch("sum_red", rsp_if.sum_red, want.sum_red);
            if (rsp_if.sum_green !== want.sum_green)
               report_mismatch("sum_green", rsp_if.sum_green, want.sum_green);
            if (rsp_if.sum_blue !== want.sum_blue)
               report_mismatch("sum_blue", rsp_if.sum_blue, want.sum_blue);
            if (rsp_if.sample_count !== want.sample_count)
               report_mismatch("sample_count", SUM_W'(rsp_if.sample_count),
                               SUM_W'(want.sample_count));
         end
      end
   end

   // End the run when no channel moves a transaction for too long.
   always @(posedge clock) begin
      if ((req_if.valid === 1'b1 && req_if.ready === 1'b1) ||
          (rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) ||
          (csr_if.valid === 1'b1 && csr_if.ready === 1'b1)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
         $display("watchdog expired at %0t", $time);
         $display("sample_splat_accumulator_top test failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Response backpressure: short and long stalls, with calm stretches.
   initial begin
      int stall;
      int calm;
      int roll;
      stall = 0;
      calm  = 0;
      rsp_if.ready = 1'b0;
      forever begin
         @(negedge clock);
         roll = $urandom_range(0, 999);
         if (stall > 0) begin
            stall--;
            rsp_if.ready <= 1'b0;
         end else begin
            if (calm > 0) calm--;
            else if (roll < 5) calm = 150;
            else if (roll < 200) stall = $urandom_range(1, 3);
            else if (roll < 215) stall = $urandom_range(10, 40);
            rsp_if.ready <= (stall == 0);
         end
      end
   end

   // Stimulus: reset, directed table, then random phases per image size
   initial begin
      bit [DIM_W-1:0] phase_width  [PHASE_COUNT];
      bit [DIM_W-1:0] phase_height [PHASE_COUNT];
      sample_req_type item;
      pixel_sums_type want;
      table_row_type  row;
      reset               = 1'b1;
      req_if.valid        = 1'b0;
      req_if.operation    = OP_ACCUMULATE;
      req_if.sample_valid = 1'b0;
      req_if.sample_x     = '0;
      req_if.sample_y     = '0;
      req_if.red          = '0;
      req_if.green        = '0;
      req_if.blue         = '0;
      req_if.read_index   = '0;
      csr_if.valid        = 1'b0;
      csr_if.index        = REG_IMAGE_WIDTH;
      csr_if.data         = '0;
      phase_width  = '{9'd256, 9'd1, 9'd0, 9'd511, 9'd256, 9'd1, 9'd13, 9'd0, 9'd0};
      phase_height = '{9'd256, 9'd1, 9'd0, 9'd300, 9'd1, 9'd256, 9'd200, 9'd0, 9'd0};
      phase_width[7]  = DIM_W'($urandom_range(2, 255));
      phase_height[7] = DIM_W'($urandom_range(2, 255));
      phase_width[8]  = DIM_W'($urandom);
      phase_height[8] = DIM_W'($urandom);

      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Walk the directed table at the reset image size
      for (int i = 0; i < DIRECTED_COUNT; i++) begin
         row  = DIRECTED_ROWS[i];
         item = '{row.operation, row.sample_valid, row.sample_x, row.sample_y,
                  row.red, row.green, row.blue, row.read_index};
         want = '{row.want_red, row.want_green, row.want_blue, row.want_count};
         send_request(item, row.typed, want);
         idle_request(draw_pause());
      end

      // Reconfigure only once the block is idle
      for (int p = 0; p < PHASE_COUNT; p++) begin
         drain_pending();
         write_register(REG_IMAGE_WIDTH, phase_width[p]);
         write_register(REG_IMAGE_HEIGHT, phase_height[p]);
         run_random_phase(ITEMS_PER_PHASE, (p % 3) == 2);
      end

      drain_pending();
      if (mismatch_count == 0) begin
         $display("sample_splat_accumulator_top test passed");
      end else begin
         $display("sample_splat_accumulator_top test failed");
      end
      $finish;
   end

endmodule
